// ===== hdl/setop_pkg.sv =====
// Package with the shared types and constants of the set operation engine.
package setop_pkg;

  localparam int MaxOut = 32;
  localparam int KeptW  = 6;

  localparam logic [2:0] OP_UNION     = 3'd0;
  localparam logic [2:0] OP_INTERSECT = 3'd1;
  localparam logic [2:0] OP_A_MINUS_B = 3'd2;
  localparam logic [2:0] OP_B_MINUS_A = 3'd3;
  localparam logic [2:0] OP_SYM_DIFF  = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_XREAD,
    ST_XLATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } setop_state_t;

  typedef struct packed {
    logic store;
    logic run_start;
    logic phase_next;
    logic x_latch;
    logic scan_step;
    logic skip_elem;
    logic keep_elem;
    logic finish;
  } setop_cmd_t;

  typedef struct packed {
    logic op_invalid;
    logic phase_done;
    logic more_phase;
    logic scan_done;
    logic keep;
    logic pend_valid;
    logic out_space;
    logic cut;
  } setop_stat_t;

endpackage

// ===== hdl/setop_dp.sv =====
// Datapath of the set operation engine: set stores, scan counters, compare and output register.
module setop_dp
  import setop_pkg::*;
#(
  parameter int SET_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] element,
  input  logic               to_set_b,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  setop_cmd_t         cmd,
  output setop_stat_t        stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] result_element,
  output logic               last_result,
  output logic               empty_set,
  output logic               dropped_input
);

  localparam int CW = $clog2(SET_DEPTH + 1);
  localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

  logic [31:0]      mem_a [SET_DEPTH];
  logic [31:0]      mem_b [SET_DEPTH];
  logic [31:0]      rd_a;
  logic [31:0]      rd_b;
  logic [CW-1:0]    count_a;
  logic [CW-1:0]    count_b;
  logic             overflow;
  logic [2:0]       operation;
  logic             phase;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic             found;
  logic             cmp_valid;
  logic             pend_valid;
  logic [31:0]      pend;
  logic [31:0]      cur_x;
  logic [KeptW-1:0] kept;

  logic [CW-1:0] nx;
  logic [CW-1:0] ny;
  logic [CW-1:0] ny_eff;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [31:0]   rd_y;
  logic          j_live;
  logic          want_in;
  logic          wr_a;
  logic          wr_b;
  logic          emit_mid;

  assign nx      = phase ? count_b : count_a;
  assign ny      = phase ? count_a : count_b;
  assign ny_eff  = (!phase && (operation == OP_UNION)) ? '0 : ny;
  assign addr_a  = phase ? j[AW-1:0] : i[AW-1:0];
  assign addr_b  = phase ? i[AW-1:0] : j[AW-1:0];
  assign rd_y    = phase ? rd_a : rd_b;
  assign j_live  = (j < ny_eff);
  assign want_in = (operation == OP_INTERSECT);
  assign wr_a    = cmd.store && !to_set_b && (count_a < CW'(SET_DEPTH));
  assign wr_b    = cmd.store && to_set_b && (count_b < CW'(SET_DEPTH));
  assign emit_mid = cmd.keep_elem && pend_valid;

  always_comb begin
    stat.op_invalid = (operation > OP_SYM_DIFF);
    stat.phase_done = (i >= nx);
    stat.more_phase = !phase && ((operation == OP_UNION) || (operation == OP_SYM_DIFF));
    stat.scan_done  = found || (!cmp_valid && !j_live);
    stat.keep       = (found == want_in);
    stat.pend_valid = pend_valid;
    stat.out_space  = !out_valid || out_ready;
    stat.cut        = (kept == KeptW'(MaxOut - 1));
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[count_a[AW-1:0]] <= element;
    end
    rd_a <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[count_b[AW-1:0]] <= element;
    end
    rd_b <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      overflow   <= 1'b0;
      operation  <= OP_UNION;
      phase      <= 1'b0;
      i          <= '0;
      j          <= '0;
      found      <= 1'b0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      kept       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        operation <= cfg_wr_data;
      end
      if (wr_a) begin
        count_a <= count_a + 1'b1;
      end
      if (wr_b) begin
        count_b <= count_b + 1'b1;
      end
      if (cmd.store && !wr_a && !wr_b) begin
        overflow <= 1'b1;
      end
      if (cmd.run_start) begin
        phase      <= (operation == OP_B_MINUS_A);
        i          <= '0;
        pend_valid <= 1'b0;
        kept       <= '0;
      end
      if (cmd.phase_next) begin
        phase <= 1'b1;
        i     <= '0;
      end
      if (cmd.x_latch) begin
        j         <= '0;
        found     <= 1'b0;
        cmp_valid <= 1'b0;
      end
      if (cmd.scan_step) begin
        cmp_valid <= j_live;
        if (j_live) begin
          j <= j + 1'b1;
        end
        if (cmp_valid && (rd_y == cur_x)) begin
          found <= 1'b1;
        end
      end
      if (cmd.skip_elem) begin
        i <= i + 1'b1;
      end
      if (cmd.keep_elem) begin
        pend_valid <= 1'b1;
        kept       <= kept + 1'b1;
        i          <= i + 1'b1;
      end
      if (cmd.finish) begin
        count_a  <= '0;
        count_b  <= '0;
        overflow <= 1'b0;
      end
      if (emit_mid || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.x_latch) begin
      cur_x <= phase ? rd_b : rd_a;
    end
    if (cmd.keep_elem) begin
      pend <= cur_x;
    end
    if (emit_mid) begin
      result_element <= pend;
      last_result    <= 1'b0;
      empty_set      <= 1'b0;
      dropped_input  <= overflow;
    end else if (cmd.finish) begin
      result_element <= pend_valid ? pend : '0;
      last_result    <= 1'b1;
      empty_set      <= !pend_valid;
      dropped_input  <= overflow;
    end
  end

endmodule

// ===== hdl/setop_ctrl.sv =====
// Controller state machine of the set operation engine.
module setop_ctrl
  import setop_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         carries_element,
  input  logic         ends_load,
  input  setop_stat_t  stat,
  output setop_cmd_t   cmd
);

  setop_state_t state;
  setop_state_t state_next;
  logic         accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.store = accept && carries_element;
        if (accept && ends_load) begin
          cmd.run_start = 1'b1;
          state_next    = stat.op_invalid ? ST_FINISH : ST_XREAD;
        end
      end
      ST_XREAD: begin
        if (!stat.phase_done) begin
          state_next = ST_XLATCH;
        end else if (stat.more_phase) begin
          cmd.phase_next = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_XLATCH: begin
        cmd.x_latch = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!stat.keep) begin
          cmd.skip_elem = 1'b1;
          state_next    = ST_XREAD;
        end else if (!stat.pend_valid || stat.out_space) begin
          cmd.keep_elem = 1'b1;
          state_next    = stat.cut ? ST_FINISH : ST_XREAD;
        end
      end
      ST_FINISH: begin
        if (stat.out_space) begin
          cmd.finish = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== hdl/set_operation_engine_top.sv =====
// Top level of the set operation engine: union, intersection and differences of two loaded sets.
// While loading, every request is taken at once; no result comes out until the request marked ends_load.
// Then each tested element is read, latched, scanned against the other set and decided; a match
// ends its scan early. Union and symmetric difference add a second pass with the sets swapped.
// A full output register holds the keep step and the close; one result comes per kept element.
// Reset clears the counts, the drop flag, the operation register (union) and the controller.
module set_operation_engine_top
  import setop_pkg::*;
#(
  parameter int SET_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] element,
  input  logic               to_set_b,
  input  logic               carries_element,
  input  logic               ends_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_element,
  output logic               last_result,
  output logic               empty_set,
  output logic               dropped_input,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data
);

  setop_cmd_t  cmd;
  setop_stat_t stat;

  setop_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .carries_element (carries_element),
    .ends_load       (ends_load),
    .stat            (stat),
    .cmd             (cmd)
  );

  setop_dp #(
    .SET_DEPTH (SET_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .element        (element),
    .to_set_b       (to_set_b),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .result_element (result_element),
    .last_result    (last_result),
    .empty_set      (empty_set),
    .dropped_input  (dropped_input)
  );

  a_end_stops_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ends_load) |=> !in_ready)
    else $error("input taken right after the closing request");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_set) |-> (last_result && (result_element == '0)))
    else $error("empty result not marked last or not zero");

  a_mid_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_result) |-> !in_ready)
    else $error("non-final result pending while loading");

endmodule
